// ===== rtl/core/bprq_pkg.sv =====
// ----------------------------------------------------------------------------
// bprq_pkg
// Shared types, sizes and codes of the bounded priority request queue.
// ----------------------------------------------------------------------------
package bprq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int ITEM_BITS   = 16;
   localparam int PRIO_BITS   = 8;
   localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_POP     = 1'b1;

   typedef enum logic [2:0] {
      OUT_INSERTED = 3'd0,
      OUT_MERGED   = 3'd1,
      OUT_REPLACED = 3'd2,
      OUT_DROPPED  = 3'd3,
      OUT_REJECTED = 3'd4,
      OUT_POPPED   = 3'd5,
      OUT_EMPTY    = 3'd6
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [ITEM_BITS-1:0] item;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic                 en;
      logic [IDX_BITS-1:0]  addr;
      entry_type            data;
   } store_wr_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cmp_result_type;

   typedef struct packed {
      logic                 valid;
      outcome_type          outcome;
      logic [ITEM_BITS-1:0] popped_item;
      logic [CNT_BITS-1:0]  queued_count;
   } result_type;

   function automatic logic [CNT_BITS-1:0] idx_to_cnt(input logic [IDX_BITS-1:0] idx);
      return CNT_BITS'(idx);
   endfunction

endpackage

// ===== rtl/core/bprq_store.sv =====
// ----------------------------------------------------------------------------
// bprq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bprq_store (
   input  logic                            clock,
   input  bprq_pkg::store_wr_type          wr,
   input  logic                            rd_en,
   input  logic [bprq_pkg::IDX_BITS-1:0]   rd_addr,
   output bprq_pkg::entry_type             rd_data
);

   bprq_pkg::entry_type mem [bprq_pkg::QUEUE_DEPTH];
   bprq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      // hold the last read word while no read is issued
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/bprq_cmp.sv =====
// ----------------------------------------------------------------------------
// bprq_cmp
// Shared compare unit: priority less-than and item equality.
// ----------------------------------------------------------------------------
module bprq_cmp (
   input  logic [bprq_pkg::PRIO_BITS-1:0] prio_a,
   input  logic [bprq_pkg::PRIO_BITS-1:0] prio_b,
   input  logic [bprq_pkg::ITEM_BITS-1:0] item_a,
   input  logic [bprq_pkg::ITEM_BITS-1:0] item_b,
   output bprq_pkg::cmp_result_type       result
);

   always_comb begin
      result.lt = (prio_a < prio_b);
      result.eq = (item_a == item_b);
   end

endmodule

// ===== rtl/core/bprq_ctrl.sv =====
// ----------------------------------------------------------------------------
// bprq_ctrl
// Sequencer: scans the stored entries one per cycle through the shared
// compare unit, then applies the single write that the operation needs.
// ----------------------------------------------------------------------------
module bprq_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [bprq_pkg::ITEM_BITS-1:0]  item_count,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic                            in_operation,
   input  logic [bprq_pkg::ITEM_BITS-1:0]  in_item,
   input  logic [bprq_pkg::PRIO_BITS-1:0]  in_prio,
   input  logic                            out_free,
   output bprq_pkg::result_type            result
);

   bprq_pkg::state_type                state_ff, state_in;
   logic [bprq_pkg::CNT_BITS-1:0]      count_ff, count_in;
   logic [bprq_pkg::CNT_BITS-1:0]      scan_ff, scan_in;
   logic                               pend_ff, pend_in;
   logic [bprq_pkg::IDX_BITS-1:0]      pend_idx_ff, pend_idx_in;
   logic [bprq_pkg::IDX_BITS-1:0]      ext_idx_ff, ext_idx_in;
   logic [bprq_pkg::PRIO_BITS-1:0]     ext_prio_ff, ext_prio_in;
   logic [bprq_pkg::ITEM_BITS-1:0]     ext_item_ff, ext_item_in;
   logic                               op_ff, op_in;
   logic [bprq_pkg::ITEM_BITS-1:0]     item_ff, item_in;
   logic [bprq_pkg::PRIO_BITS-1:0]     prio_ff, prio_in;
   bprq_pkg::outcome_type              outcome_ff, outcome_in;
   logic [bprq_pkg::ITEM_BITS-1:0]     popped_ff, popped_in;

   bprq_pkg::store_wr_type             wr;
   logic                               rd_en;
   bprq_pkg::entry_type                rd_data;
   logic [bprq_pkg::PRIO_BITS-1:0]     cmp_a, cmp_b;
   bprq_pkg::cmp_result_type           cmp;

   logic accept, issue, last, hit;

   bprq_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[bprq_pkg::IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   bprq_cmp u_cmp (
      .prio_a (cmp_a),
      .prio_b (cmp_b),
      .item_a (item_ff),
      .item_b (rd_data.item),
      .result (cmp)
   );

   assign accept = in_valid && in_ready;
   assign issue  = (scan_ff < count_ff);
   assign last   = pend_ff && (bprq_pkg::idx_to_cnt(pend_idx_ff) == count_ff - bprq_pkg::CNT_ONE);
   assign hit    = pend_ff && (op_ff == bprq_pkg::OP_REQUEST) && cmp.eq;

   // operand select of the shared comparator
   always_comb begin
      if (state_ff == bprq_pkg::ST_WRITE) begin
         cmp_a = prio_ff;
         cmp_b = ext_prio_ff;
      end else if (op_ff == bprq_pkg::OP_POP) begin
         cmp_a = rd_data.prio;
         cmp_b = ext_prio_ff;
      end else begin
         cmp_a = ext_prio_ff;
         cmp_b = rd_data.prio;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bprq_pkg::ST_IDLE: begin
            if (accept) begin
               if (in_operation == bprq_pkg::OP_POP && count_ff == '0) begin
                  state_in = bprq_pkg::ST_DONE;
               end else if (in_operation == bprq_pkg::OP_REQUEST && in_item >= item_count) begin
                  state_in = bprq_pkg::ST_DONE;
               end else begin
                  state_in = bprq_pkg::ST_SCAN;
               end
            end
         end
         bprq_pkg::ST_SCAN: begin
            if (hit || last || count_ff == '0) begin
               state_in = bprq_pkg::ST_WRITE;
            end
         end
         bprq_pkg::ST_WRITE: begin
            state_in = bprq_pkg::ST_DONE;
         end
         bprq_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bprq_pkg::ST_IDLE;
            end
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      count_in    = count_ff;
      scan_in     = scan_ff;
      pend_in     = 1'b0;
      pend_idx_in = pend_idx_ff;
      ext_idx_in  = ext_idx_ff;
      ext_prio_in = ext_prio_ff;
      ext_item_in = ext_item_ff;
      op_in       = op_ff;
      item_in     = item_ff;
      prio_in     = prio_ff;
      outcome_in  = outcome_ff;
      popped_in   = popped_ff;
      rd_en       = 1'b0;
      wr.en       = 1'b0;
      wr.addr     = ext_idx_ff;
      wr.data     = '{item: item_ff, prio: prio_ff};
      in_ready    = (state_ff == bprq_pkg::ST_IDLE);

      unique case (state_ff)
         bprq_pkg::ST_IDLE: begin
            if (accept) begin
               op_in     = in_operation;
               item_in   = in_item;
               prio_in   = in_prio;
               scan_in   = '0;
               popped_in = '0;
               if (in_operation == bprq_pkg::OP_POP) begin
                  outcome_in = bprq_pkg::OUT_EMPTY;
               end else begin
                  outcome_in = bprq_pkg::OUT_REJECTED;
               end
            end
         end
         bprq_pkg::ST_SCAN: begin
            rd_en       = issue;
            pend_in     = issue;
            pend_idx_in = scan_ff[bprq_pkg::IDX_BITS-1:0];
            if (issue) begin
               scan_in = scan_ff + bprq_pkg::CNT_ONE;
            end
            if (hit) begin
               ext_idx_in  = pend_idx_ff;
               ext_prio_in = rd_data.prio;
               outcome_in  = bprq_pkg::OUT_MERGED;
            end else begin
               // keep the first entry at the best or worst priority
               if (pend_ff && (pend_idx_ff == '0 || cmp.lt)) begin
                  ext_idx_in  = pend_idx_ff;
                  ext_prio_in = rd_data.prio;
                  ext_item_in = rd_data.item;
               end
               if (last || count_ff == '0) begin
                  if (op_ff == bprq_pkg::OP_POP) begin
                     outcome_in = bprq_pkg::OUT_POPPED;
                  end else if (count_ff == bprq_pkg::CNT_FULL) begin
                     outcome_in = bprq_pkg::OUT_REPLACED;
                  end else begin
                     outcome_in = bprq_pkg::OUT_INSERTED;
                  end
               end
            end
         end
         bprq_pkg::ST_WRITE: begin
            unique case (outcome_ff)
               bprq_pkg::OUT_MERGED: begin
                  wr.en = cmp.lt;
               end
               bprq_pkg::OUT_INSERTED: begin
                  wr.en    = 1'b1;
                  wr.addr  = count_ff[bprq_pkg::IDX_BITS-1:0];
                  count_in = count_ff + bprq_pkg::CNT_ONE;
               end
               bprq_pkg::OUT_REPLACED: begin
                  wr.en = cmp.lt;
                  if (!cmp.lt) begin
                     outcome_in = bprq_pkg::OUT_DROPPED;
                  end
               end
               bprq_pkg::OUT_POPPED: begin
                  // read data still holds the last entry: move it into the hole
                  wr.en     = 1'b1;
                  wr.data   = rd_data;
                  count_in  = count_ff - bprq_pkg::CNT_ONE;
                  popped_in = ext_item_ff;
               end
               default: begin
               end
            endcase
         end
         bprq_pkg::ST_DONE: begin
         end
      endcase

      result.valid        = (state_ff == bprq_pkg::ST_DONE);
      result.outcome      = outcome_ff;
      result.popped_item  = popped_ff;
      result.queued_count = count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bprq_pkg::ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      ext_idx_ff  <= ext_idx_in;
      ext_prio_ff <= ext_prio_in;
      ext_item_ff <= ext_item_in;
      op_ff       <= op_in;
      item_ff     <= item_in;
      prio_ff     <= prio_in;
      outcome_ff  <= outcome_in;
      popped_ff   <= popped_in;
   end

endmodule

// ===== rtl/core/bounded_priority_request_queue.sv =====
// ----------------------------------------------------------------------------
// bounded_priority_request_queue
// Bounded, unordered queue of item numbers with priorities and merging of
// duplicate requests.
// ----------------------------------------------------------------------------
// One transaction at a time: a request or pop with entries queued is paced by
// the entry memory's single read port, which the sequencer sweeps one entry
// per cycle through a shared compare unit before at most one write-back. A
// rejected request or a pop of an empty queue skips the scan. The next
// transaction is accepted while the previous result waits in the output
// register.
module bounded_priority_request_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [15:0]                     csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_operation,
   input  logic [bprq_pkg::ITEM_BITS-1:0]  req_item,
   input  logic [bprq_pkg::PRIO_BITS-1:0]  req_priority_req,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_outcome,
   output logic [bprq_pkg::ITEM_BITS-1:0]  rsp_popped_item,
   output logic [bprq_pkg::CNT_BITS-1:0]   rsp_queued_count
);

   logic [15:0]                     item_count_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   bprq_pkg::outcome_type           rsp_outcome_ff;
   logic [bprq_pkg::ITEM_BITS-1:0]  rsp_popped_ff;
   logic [bprq_pkg::CNT_BITS-1:0]   rsp_count_ff;
   logic                            out_free;
   bprq_pkg::result_type            result;

   assign out_free = !rsp_valid_ff || rsp_ready;

   bprq_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .item_count   (item_count_ff),
      .in_valid     (req_valid),
      .in_ready     (req_ready),
      .in_operation (req_operation),
      .in_item      (req_item),
      .in_prio      (req_priority_req),
      .out_free     (out_free),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            item_count_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_free && result.valid) begin
         rsp_outcome_ff <= result.outcome;
         rsp_popped_ff  <= result.popped_item;
         rsp_count_ff   <= result.queued_count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_popped_item  = rsp_popped_ff;
   assign rsp_queued_count = rsp_count_ff;

   // the queue never holds more entries than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_queued_count <= bprq_pkg::CNT_FULL))
      else $error("queued count above depth");

   // only a pop returns an item
   a_popped_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_outcome != bprq_pkg::OUT_POPPED) |-> (rsp_popped_item == '0))
      else $error("popped item set without a pop");

   // a new transaction is never taken while a result is being handed over
   a_ready_done: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !result.valid)
      else $error("input ready while result pending in sequencer");

endmodule
